/* rtl/core/orp_pkg.sv */
// orp_pkg: types, constants and field arithmetic for the odometry record parser
// used by every module of the parser but orp_in_stage; depends on nothing
package orp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_W = 32;
	localparam int MAG_W = VALUE_WIDTH;
	localparam int PROD_W = VALUE_WIDTH + 4;
	localparam int CALC_W = VALUE_WIDTH + COUNT_W + 1;

	localparam logic [MAG_W-1:0] MAG_LIM = {1'b1, {(MAG_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] MAG_MAX = MAG_LIM - MAG_W'(1);

	localparam logic [7:0] CH_S = 8'd115;
	localparam logic [7:0] CH_G = 8'd103;
	localparam logic [7:0] CH_E = 8'd101;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [23:0] HDR_PREFIX = {CH_S, CH_G, CH_E};

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_SKIP  = 2'd1,
		PH_LEFT  = 2'd2,
		PH_RIGHT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             digit;
		logic             done;
		logic             sat;
	} field_t;

	typedef struct packed {
		logic signed [COUNT_W-1:0] value;
		status_t                   status;
	} close_t;

	typedef struct packed {
		logic                      emit;
		logic signed [COUNT_W-1:0] left_count;
		logic signed [COUNT_W-1:0] right_count;
		status_t                   status;
	} result_t;

	localparam field_t FIELD_CLEAR = '{mag: '0, neg: 1'b0, digit: 1'b0, done: 1'b0, sat: 1'b0};

	function automatic field_t field_byte(field_t f, logic [7:0] b);
		field_t            r;
		logic [PROD_W-1:0] ext;
		logic [PROD_W-1:0] t;
		r = f;
		ext = PROD_W'(f.mag);
		t = (ext << 3) + (ext << 1) + PROD_W'(b - CH_ZERO);
		if (!f.done) begin
			if (b >= CH_ZERO && b <= CH_NINE) begin
				r.digit = 1'b1;
				if (t > PROD_W'(MAG_LIM)) begin
					r.mag = MAG_LIM;
					r.sat = 1'b1;
				end else begin
					r.mag = t[MAG_W-1:0];
				end
			end else if (b == CH_MINUS && !f.neg && !f.digit) begin
				r.neg = 1'b1;
			end else begin
				r.done = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic close_t field_close(field_t f);
		close_t            r;
		logic [MAG_W-1:0]  m;
		logic              sat;
		logic [CALC_W-1:0] wide;
		m = f.mag;
		sat = f.sat;
		wide = '0;
		r.status = ST_OK;
		if (!f.digit) begin
			r.status = ST_EMPTY;
		end else if (f.neg) begin
			wide = -CALC_W'(m);
			if (sat) r.status = ST_SAT;
		end else begin
			if (m > MAG_MAX) begin
				m = MAG_MAX;
				sat = 1'b1;
			end
			wide = CALC_W'(m);
			if (sat) r.status = ST_SAT;
		end
		r.value = wide[COUNT_W-1:0];
		return r;
	endfunction

endpackage

/* rtl/core/orp_if.sv */
// orp_byte_if and orp_rec_if: valid/ready channels of the odometry record parser
// depends on orp_pkg for the count width
interface orp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface orp_rec_if;
	logic                               valid;
	logic                               ready;
	logic signed [orp_pkg::COUNT_W-1:0] left_count;
	logic signed [orp_pkg::COUNT_W-1:0] right_count;
	logic [1:0]                         record_status;

	modport source (output valid, output left_count, output right_count,
		output record_status, input ready);
	modport sink (input valid, input left_count, input right_count,
		input record_status, output ready);
endinterface

/* rtl/core/orp_in_stage.sv */
// orp_in_stage: input register holding one received byte until the parser takes it
// depends on orp_byte_if
module orp_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	orp_byte_if.sink         rx,
	input  logic             advance,
	output logic             valid_s1,
	output logic [7:0]       byte_s1
);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end
endmodule

/* rtl/core/orp_parser.sv */
// orp_parser: header hunt, field accumulation and record close, one byte per step
// depends on orp_pkg for phases, field arithmetic and the result struct
module orp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_s1,
	output orp_pkg::result_t res
);
	import orp_pkg::*;

	phase_t                    phase_q, phase_d;
	logic [23:0]               window_q, window_d;
	field_t                    field_q, field_d;
	logic signed [COUNT_W-1:0] left_q, left_d;
	status_t                   err_q, err_d;
	close_t                    closed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			window_q <= '0;
			field_q  <= FIELD_CLEAR;
			left_q   <= '0;
			err_q    <= ST_OK;
		end else if (step) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			field_q  <= field_d;
			left_q   <= left_d;
			err_q    <= err_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		window_d = window_q;
		field_d = field_q;
		left_d = left_q;
		err_d = err_q;
		closed = field_close(field_q);
		res.emit = 1'b0;
		res.left_count = left_q;
		res.right_count = closed.value;
		if (err_q == ST_EMPTY || closed.status == ST_EMPTY) begin
			res.status = ST_EMPTY;
		end else if (err_q == ST_SAT || closed.status == ST_SAT) begin
			res.status = ST_SAT;
		end else begin
			res.status = ST_OK;
		end
		case (phase_q)
			PH_HUNT: begin
				if (window_q == HDR_PREFIX && byte_s1 == CH_G) begin
					window_d = '0;
					phase_d = PH_SKIP;
				end else begin
					window_d = {window_q[15:0], byte_s1};
				end
			end
			PH_SKIP: begin
				field_d = FIELD_CLEAR;
				err_d = ST_OK;
				phase_d = PH_LEFT;
			end
			PH_LEFT: begin
				if (byte_s1 == CH_COMMA) begin
					left_d = closed.value;
					err_d = closed.status;
					field_d = FIELD_CLEAR;
					phase_d = PH_RIGHT;
				end else begin
					field_d = field_byte(field_q, byte_s1);
				end
			end
			PH_RIGHT: begin
				if (byte_s1 == CH_NL) begin
					res.emit = 1'b1;
					field_d = FIELD_CLEAR;
					left_d = '0;
					err_d = ST_OK;
					window_d = '0;
					phase_d = PH_HUNT;
				end else begin
					field_d = field_byte(field_q, byte_s1);
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	a_idle_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT || phase_q == PH_SKIP) |-> (field_q == FIELD_CLEAR))
		else $error("field state not clear outside a record");

	a_mag_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		field_q.mag <= MAG_LIM)
		else $error("magnitude above range limit");

	a_window_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HUNT |-> window_q == '0)
		else $error("header window not empty inside a record");

	a_newline_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_RIGHT && byte_s1 == CH_NL) |=> phase_q == PH_HUNT)
		else $error("record did not end at newline");

	a_emit_right_only: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |-> phase_q == PH_RIGHT)
		else $error("result outside the right field");
endmodule

/* rtl/core/orp_out_stage.sv */
// orp_out_stage: result register holding one finished record until its transfer
// depends on orp_pkg for the result struct and on orp_rec_if
module orp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  orp_pkg::result_t res,
	output logic             free,
	orp_rec_if.source        rec
);
	import orp_pkg::*;

	logic                      valid_q;
	logic signed [COUNT_W-1:0] left_q;
	logic signed [COUNT_W-1:0] right_q;
	status_t                   status_q;

	assign free = !valid_q || rec.ready;
	assign rec.valid = valid_q;
	assign rec.left_count = left_q;
	assign rec.right_count = right_q;
	assign rec.record_status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rec.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q   <= res.left_count;
			right_q  <= res.right_count;
			status_q <= res.status;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register overwritten before transfer");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not shown");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (status_q == ST_OK || status_q == ST_EMPTY || status_q == ST_SAT))
		else $error("illegal record status");
endmodule

/* rtl/core/odometry_record_parser.sv */
// odometry_record_parser: top level, input register, parser and result register
// depends on orp_pkg, orp_if, orp_in_stage, orp_parser, orp_out_stage
//
//  channel  dir  payload                                    transfer
//  rx       in   rx_byte[7:0]                               valid && ready
//  rec      out  left_count[31:0] right_count[31:0]         valid && ready
//                record_status[1:0]
//
// one byte per cycle unless a record waits on a stalled rec; a record is closed by
// the parser from its newline in the input register and shown via the result register
// arst_n clears the phase to header hunt and empties both registers
// a stalled rec holds only bytes that would close a record; other bytes keep
// flowing while a result waits
module odometry_record_parser (
	input  logic       clk,
	input  logic       arst_n,
	orp_byte_if.sink   rx,
	orp_rec_if.source  rec
);
	import orp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       free;
	result_t    res;

	assign advance = valid_s1 && (!res.emit || free);

	orp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	orp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	orp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res.emit),
		.res    (res),
		.free   (free),
		.rec    (rec)
	);
endmodule
